@@ hdl/scc_pkg.sv @@
// Package for the scan sector clearance core: sizes, register indexes,
// and the structs passed between the config, filter and accumulator blocks.
// No dependencies.
package scc_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int RANGE_BITS_DEF  = 16;

    localparam int NUM_SECTORS = 5;
    localparam int THRESH_W    = 16;
    localparam int IDX_W       = 11;
    localparam int WIDTH_W     = 9;
    localparam int BOUND_W     = 12;
    localparam int NEED_W      = THRESH_W + BOUND_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET   = 16'd200;
    localparam int                  LOW_READING_MM = 10;

    // Sector order: right, front right, front, front left, left
    localparam int SEC_RIGHT       = 0;
    localparam int SEC_FRONT_RIGHT = 1;
    localparam int SEC_FRONT       = 2;
    localparam int SEC_FRONT_LEFT  = 3;
    localparam int SEC_LEFT        = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD    = 3'd0,
        CFG_RIGHT_LO     = 3'd1,
        CFG_RIGHT_HI     = 3'd2,
        CFG_CENTER_LO    = 3'd3,
        CFG_CENTER_WIDTH = 3'd4,
        CFG_LEFT_LO      = 3'd5,
        CFG_LEFT_HI      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_SECTORS-1:0][BOUND_W-1:0] lo;
        logic [NUM_SECTORS-1:0][BOUND_W-1:0] hi;
    } scc_bounds_t;

    typedef struct packed {
        logic [NUM_SECTORS-1:0][NEED_W-1:0] need;
        logic [NUM_SECTORS-1:0]             empty;
    } scc_limits_t;

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [NUM_SECTORS-1:0] hit;
    } scc_stage_t;

endpackage

@@ hdl/scan_sector_clearance_core.sv @@
// Top level of the scan sector clearance core.
// Depends on scc_pkg, scc_cfg, scc_filter and scc_accum.
//
//   channel   ports                          moves
//   s_        s_valid/s_ready                one range sample + last mark
//   m_        m_valid/m_ready                five sector clear flags
//   cfg_      cfg_we/cfg_index/cfg_wdata     register write, no wait
//
// One item per cycle sustained. A sample passes the input register, the
// filter stage (low-reading replacement, index, sector hits) and is summed
// when it leaves that stage; a last sample loads the result register, which
// drives the flags. Only a held result blocks, and only when the next last
// sample reaches it. Reset is synchronous and clears valid flags, sums,
// index and previous value and resets the config registers; derived sector
// bounds are registered from them and the limits from those bounds.
module scan_sector_clearance_core #(
    parameter int MAX_SAMPLES = scc_pkg::MAX_SAMPLES_DEF,
    parameter int RANGE_BITS  = scc_pkg::RANGE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [scc_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [RANGE_BITS-1:0]          s_range_mm,
    input  logic                           s_last_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_right_clear,
    output logic                           m_front_right_clear,
    output logic                           m_front_clear,
    output logic                           m_front_left_clear,
    output logic                           m_left_clear
);
    import scc_pkg::*;

    scc_bounds_t           bounds;
    scc_limits_t           limits;
    scc_stage_t            stage;
    logic [RANGE_BITS-1:0] stage_clean;
    logic                  stage_retire;

    scc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .bounds    (bounds),
        .limits    (limits)
    );

    scc_filter #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .RANGE_BITS  (RANGE_BITS)
    ) u_filter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_mm    (s_range_mm),
        .s_last_sample (s_last_sample),
        .bounds        (bounds),
        .stage_retire  (stage_retire),
        .stage         (stage),
        .stage_clean   (stage_clean)
    );

    scc_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .RANGE_BITS  (RANGE_BITS)
    ) u_accum (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .stage               (stage),
        .stage_clean         (stage_clean),
        .limits              (limits),
        .stage_retire        (stage_retire),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_right_clear       (m_right_clear),
        .m_front_right_clear (m_front_right_clear),
        .m_front_clear       (m_front_clear),
        .m_front_left_clear  (m_front_left_clear),
        .m_left_clear        (m_left_clear)
    );

endmodule

@@ hdl/scc_cfg.sv @@
// Configuration registers and the sector bounds and thresholds derived from them.
// Depends on scc_pkg.
module scc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [scc_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output scc_pkg::scc_bounds_t           bounds,
    output scc_pkg::scc_limits_t           limits
);
    import scc_pkg::*;

    logic [THRESH_W-1:0] threshold_reg;
    logic [IDX_W-1:0]    right_lo_reg;
    logic [IDX_W-1:0]    right_hi_reg;
    logic [IDX_W-1:0]    center_lo_reg;
    logic [WIDTH_W-1:0]  center_width_reg;
    logic [IDX_W-1:0]    left_lo_reg;
    logic [IDX_W-1:0]    left_hi_reg;

    scc_bounds_t         bounds_reg;
    scc_bounds_t         bounds_next;
    scc_limits_t         limits_reg;
    scc_limits_t         limits_next;
    logic [BOUND_W-1:0]  width_ext;
    logic [BOUND_W-1:0]  center_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESH_RESET;
            right_lo_reg     <= '0;
            right_hi_reg     <= '0;
            center_lo_reg    <= '0;
            center_width_reg <= '0;
            left_lo_reg      <= '0;
            left_hi_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_THRESHOLD:    threshold_reg    <= cfg_wdata[THRESH_W-1:0];
                CFG_RIGHT_LO:     right_lo_reg     <= cfg_wdata[IDX_W-1:0];
                CFG_RIGHT_HI:     right_hi_reg     <= cfg_wdata[IDX_W-1:0];
                CFG_CENTER_LO:    center_lo_reg    <= cfg_wdata[IDX_W-1:0];
                CFG_CENTER_WIDTH: center_width_reg <= cfg_wdata[WIDTH_W-1:0];
                CFG_LEFT_LO:      left_lo_reg      <= cfg_wdata[IDX_W-1:0];
                CFG_LEFT_HI:      left_hi_reg      <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        width_ext  = BOUND_W'(center_width_reg);
        center_ext = BOUND_W'(center_lo_reg);

        bounds_next.lo[SEC_RIGHT]       = BOUND_W'(right_lo_reg);
        bounds_next.hi[SEC_RIGHT]       = BOUND_W'(right_hi_reg);
        bounds_next.lo[SEC_FRONT_RIGHT] = center_ext;
        bounds_next.hi[SEC_FRONT_RIGHT] = center_ext + width_ext;
        bounds_next.lo[SEC_FRONT]       = center_ext + width_ext;
        bounds_next.hi[SEC_FRONT]       = center_ext + {width_ext[BOUND_W-2:0], 1'b0};
        bounds_next.lo[SEC_FRONT_LEFT]  = center_ext + {width_ext[BOUND_W-2:0], 1'b0};
        bounds_next.hi[SEC_FRONT_LEFT]  = center_ext + {width_ext[BOUND_W-2:0], 1'b0}
                                          + width_ext;
        bounds_next.lo[SEC_LEFT]        = BOUND_W'(left_lo_reg);
        bounds_next.hi[SEC_LEFT]        = BOUND_W'(left_hi_reg);
    end

    always_comb begin
        for (int s = 0; s < NUM_SECTORS; s++) begin
            limits_next.empty[s] = (bounds_reg.hi[s] <= bounds_reg.lo[s]);
            limits_next.need[s]  = NEED_W'(threshold_reg)
                                   * NEED_W'(bounds_reg.hi[s] - bounds_reg.lo[s]);
        end
    end

    // Recomputed every cycle; limits are registered from the registered bounds
    always_ff @(posedge aclk) begin
        bounds_reg <= bounds_next;
        limits_reg <= limits_next;
    end

    assign bounds = bounds_reg;
    assign limits = limits_reg;

endmodule

@@ hdl/scc_filter.sv @@
// Input register, sample indexing, low-reading replacement and sector hit test.
// Depends on scc_pkg; bounds come from scc_cfg.
module scc_filter #(
    parameter int MAX_SAMPLES = scc_pkg::MAX_SAMPLES_DEF,
    parameter int RANGE_BITS  = scc_pkg::RANGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RANGE_BITS-1:0] s_range_mm,
    input  logic                  s_last_sample,
    input  scc_pkg::scc_bounds_t  bounds,
    input  logic                  stage_retire,
    output scc_pkg::scc_stage_t   stage,
    output logic [RANGE_BITS-1:0] stage_clean
);
    import scc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > BOUND_W) ? CNT_W : BOUND_W;
    localparam int RB    = RANGE_BITS;
    localparam longint unsigned RECIP_INT = (64'd1 << RB) / 64'd5;
    localparam logic [RB-1:0] RECIP     = RB'(RECIP_INT);
    localparam logic [RB-1:0] RANGE_MAX = {RB{1'b1}};
    localparam logic [RB-1:0] LOW_MM    = RB'(LOW_READING_MM);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    logic                in_valid_reg;
    logic [RB-1:0]       range_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [RB-1:0]       prev_reg;
    scc_stage_t          stage_reg;
    logic [RB-1:0]       clean_reg;

    logic                stage_free;
    logic                advance;
    logic                accept;
    logic [2*RB-1:0]     prod;
    logic [RB-1:0]       quot;
    logic [RB+2:0]       rem;
    logic [RB-1:0]       quot_fix;
    logic [RB:0]         scaled;
    logic                low_reading;
    logic [RB-1:0]       clean;
    logic [CMP_W-1:0]    cnt_ext;
    logic                cnt_live;
    logic [NUM_SECTORS-1:0] hit;

    assign stage_free = !stage_reg.valid || stage_retire;
    assign advance    = in_valid_reg && stage_free;
    assign s_ready    = !in_valid_reg || stage_free;
    assign accept     = s_valid && s_ready;

    // prev * 6 / 5 = prev + prev / 5; quotient by reciprocal, one-step fixup
    always_comb begin
        prod     = {{RB{1'b0}}, prev_reg} * {{RB{1'b0}}, RECIP};
        quot     = prod[2*RB-1:RB];
        rem      = {3'b000, prev_reg} - ({1'b0, quot, 2'b00} + {3'b000, quot});
        quot_fix = quot + RB'(rem >= (RB+3)'(5));
        scaled   = {1'b0, prev_reg} + {1'b0, quot_fix};
        low_reading = (range_reg <= LOW_MM) && (cnt_reg != '0);
        if (!low_reading) begin
            clean = range_reg;
        end else if (scaled[RB]) begin
            clean = RANGE_MAX;
        end else begin
            clean = scaled[RB-1:0];
        end
    end

    always_comb begin
        cnt_ext  = CMP_W'(cnt_reg);
        cnt_live = (cnt_reg < CNT_MAX);
        for (int s = 0; s < NUM_SECTORS; s++) begin
            hit[s] = cnt_live && (cnt_ext >= CMP_W'(bounds.lo[s]))
                     && (cnt_ext < CMP_W'(bounds.hi[s]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            stage_reg.valid <= 1'b0;
            cnt_reg         <= '0;
            prev_reg        <= '0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                stage_reg.valid <= 1'b1;
                stage_reg.last  <= last_reg;
                stage_reg.hit   <= hit;
            end else if (stage_retire) begin
                stage_reg.valid <= 1'b0;
            end
            if (advance) begin
                prev_reg <= clean;
                if (last_reg) begin
                    cnt_reg <= '0;
                end else if (cnt_live) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            range_reg <= s_range_mm;
            last_reg  <= s_last_sample;
        end
        if (advance) begin
            clean_reg <= clean;
        end
    end

    assign stage       = stage_reg;
    assign stage_clean = clean_reg;

endmodule

@@ hdl/scc_accum.sv @@
// Per-sector sums, end-of-scan threshold compare and the result register.
// Depends on scc_pkg; fed by scc_filter and scc_cfg.
module scc_accum #(
    parameter int MAX_SAMPLES = scc_pkg::MAX_SAMPLES_DEF,
    parameter int RANGE_BITS  = scc_pkg::RANGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  scc_pkg::scc_stage_t   stage,
    input  logic [RANGE_BITS-1:0] stage_clean,
    input  scc_pkg::scc_limits_t  limits,
    output logic                  stage_retire,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_right_clear,
    output logic                  m_front_right_clear,
    output logic                  m_front_clear,
    output logic                  m_front_left_clear,
    output logic                  m_left_clear
);
    import scc_pkg::*;

    localparam int SUM_W = RANGE_BITS + $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (SUM_W > NEED_W) ? SUM_W : NEED_W;

    logic [NUM_SECTORS-1:0][SUM_W-1:0] sum_reg;
    logic [NUM_SECTORS-1:0][SUM_W-1:0] sum_next;
    logic [NUM_SECTORS-1:0]            clear_next;
    logic [NUM_SECTORS-1:0]            clear_reg;
    logic                              m_valid_reg;
    logic                              emit;

    assign stage_retire = stage.valid && (!stage.last || !m_valid_reg || m_ready);
    assign emit         = stage_retire && stage.last;

    always_comb begin
        for (int s = 0; s < NUM_SECTORS; s++) begin
            sum_next[s]   = sum_reg[s] + (stage.hit[s] ? SUM_W'(stage_clean) : '0);
            clear_next[s] = limits.empty[s]
                            || (CMP_W'(sum_next[s]) >= CMP_W'(limits.need[s]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (stage_retire) begin
                sum_reg <= stage.last ? '0 : sum_next;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            clear_reg <= clear_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_right_clear       = clear_reg[SEC_RIGHT];
    assign m_front_right_clear = clear_reg[SEC_FRONT_RIGHT];
    assign m_front_clear       = clear_reg[SEC_FRONT];
    assign m_front_left_clear  = clear_reg[SEC_FRONT_LEFT];
    assign m_left_clear        = clear_reg[SEC_LEFT];

endmodule
